// ===== rtl/sliding_window_median_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window median: assertion macros
// Shared concurrent check forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Same-cycle implication.
`define SWM_CHECK(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication.
`define SWM_CHECK_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median package
// Sizes, cell interface types and sample key conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	localparam int DATA_W      = 64;
	localparam int CFG_W       = 7;
	localparam int SAMPLE_BITS = 64;
	localparam int WINDOW_MAX  = 64;
	localparam int WIN_W       = $clog2(WINDOW_MAX + 1);
	localparam int AGE_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	localparam logic [WIN_W-1:0] WS_RESET = WIN_W'(3);
	localparam logic [SAMPLE_BITS-1:0] KEY_MSB = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] key;
		logic [AGE_W-1:0]       age;
	} cell_entry_t;

	typedef struct packed {
		logic ahead;
		logic rm;
	} cell_flags_t;

	typedef struct packed {
		logic             occupied;
		logic             full;
		logic [AGE_W-1:0] oldest_age;
		logic             tap;
	} cell_ctrl_t;

	function automatic logic [SAMPLE_BITS-1:0] to_key(input logic [DATA_W-1:0] raw);
		return raw[SAMPLE_BITS-1:0] ^ KEY_MSB;
	endfunction

	function automatic logic signed [DATA_W-1:0] from_key(input logic [SAMPLE_BITS-1:0] key);
		logic signed [SAMPLE_BITS-1:0] v;
		v = key ^ KEY_MSB;
		return DATA_W'(v);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding window median: sort cell
// Holds one sorted entry with its age; takes its own, its lower or its upper
// neighbor's entry, or the new key, so the row stays ordered.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
	input  wire logic                            clk,
	input  wire logic                            shift_en,
	input  wire logic [swm_pkg::SAMPLE_BITS-1:0] new_key,
	input  wire swm_pkg::cell_ctrl_t             ctrl,
	input  wire swm_pkg::cell_entry_t            prev_entry,
	input  wire swm_pkg::cell_flags_t            prev_flags,
	input  wire logic                            prev_gone,
	input  wire swm_pkg::cell_entry_t            next_entry,
	input  wire swm_pkg::cell_flags_t            next_flags,
	input  wire logic                            gone,
	output swm_pkg::cell_entry_t                 entry,
	output swm_pkg::cell_flags_t                 flags,
	output logic [swm_pkg::SAMPLE_BITS-1:0]      tap_key
);

	swm_pkg::cell_entry_t entry_q;
	swm_pkg::cell_entry_t entry_d;
	swm_pkg::cell_entry_t self_src;
	swm_pkg::cell_entry_t prev_src;
	logic                 self_ahead;
	logic                 prev_ahead;

	assign flags.ahead = ctrl.occupied && (entry_q.key <= new_key);
	assign flags.rm    = ctrl.full && ctrl.occupied && (entry_q.age == ctrl.oldest_age);

	assign self_src   = gone ? next_entry : entry_q;
	assign self_ahead = gone ? next_flags.ahead : flags.ahead;
	assign prev_src   = prev_gone ? entry_q : prev_entry;
	assign prev_ahead = prev_gone ? flags.ahead : prev_flags.ahead;

	always_comb begin
		priority if (self_ahead) begin
			entry_d.key = self_src.key;
			entry_d.age = swm_pkg::AGE_W'(self_src.age + 1'b1);
		end else if (prev_ahead) begin
			entry_d.key = new_key;
			entry_d.age = '0;
		end else begin
			entry_d.key = prev_src.key;
			entry_d.age = swm_pkg::AGE_W'(prev_src.age + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= entry_d;
		end
	end

	assign entry   = entry_q;
	assign tap_key = ctrl.tap ? entry_q.key : '0;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
// An accepted word updates the sort cell row and the staging flag; its median word is then registered at the output.
// Throughput: one sample word per cycle, set by the sort cell row, unless a stalled median output holds input.
// A stalled median output holds at most one further result before input stalls.
// Reset clears fill count, window size (to 3) and output valid; cells need no reset.
// ----------------------------------------------------------------------------
// Sliding window median
// Running median over the last window_size samples using a row of sort cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_median_defines.svh"

module sliding_window_median (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [swm_pkg::CFG_W-1:0]         window_size,
	input  wire logic                              window_size_valid,
	output logic                                   window_size_ready,
	input  wire logic signed [swm_pkg::DATA_W-1:0] sample,
	input  wire logic                              sample_valid,
	output logic                                   sample_ready,
	output logic signed [swm_pkg::DATA_W-1:0]      median_value,
	output logic                                   median_valid,
	input  wire logic                              median_ready
);

	localparam int WMAX = swm_pkg::WINDOW_MAX;

	logic [swm_pkg::WIN_W-1:0]       ws_q;
	logic [swm_pkg::WIN_W-1:0]       fill_q;
	logic [swm_pkg::WIN_W-1:0]       fill_next;
	logic [swm_pkg::WIN_W-1:0]       ws_new;
	logic [swm_pkg::WIN_W-1:0]       tap_idx;
	logic [swm_pkg::AGE_W-1:0]       oldest_age;
	logic                            full;
	logic                            emit_next;
	logic                            emit_s1;
	logic                            out_valid_q;
	logic                            out_load;
	logic                            in_fire;
	logic                            cfg_fire;
	logic [swm_pkg::SAMPLE_BITS-1:0] new_key;
	logic [swm_pkg::SAMPLE_BITS-1:0] tap_or;
	logic signed [swm_pkg::DATA_W-1:0] median_q;

	swm_pkg::cell_entry_t            entry_arr [WMAX];
	swm_pkg::cell_flags_t            flag_arr [WMAX];
	logic [swm_pkg::SAMPLE_BITS-1:0] tap_arr [WMAX];
	logic [WMAX-1:0]                 rm_vec;
	logic [WMAX-1:0]                 gone_vec;

	assign new_key    = swm_pkg::to_key(sample);
	assign full       = (fill_q == ws_q);
	assign fill_next  = full ? fill_q : swm_pkg::WIN_W'(fill_q + 1'b1);
	assign emit_next  = (fill_next == ws_q);
	assign tap_idx    = ws_q >> 1;
	assign oldest_age = swm_pkg::AGE_W'(ws_q - 1'b1);

	assign sample_ready      = !emit_s1 || !out_valid_q || median_ready;
	assign window_size_ready = !emit_s1 && !out_valid_q;
	assign in_fire           = sample_valid && sample_ready;
	assign cfg_fire          = window_size_valid && window_size_ready;
	assign out_load          = emit_s1 && (!out_valid_q || median_ready);

	always_comb begin
		priority if (window_size == '0) begin
			ws_new = swm_pkg::WIN_W'(1);
		end else if (int'(window_size) > WMAX) begin
			ws_new = swm_pkg::WIN_W'(WMAX);
		end else begin
			ws_new = swm_pkg::WIN_W'(window_size);
		end
	end

	for (genvar g = 0; g < WMAX; g++) begin : g_cell
		swm_pkg::cell_ctrl_t  ctrl;
		swm_pkg::cell_entry_t prev_entry;
		swm_pkg::cell_flags_t prev_flags;
		logic                 prev_gone;
		swm_pkg::cell_entry_t next_entry;
		swm_pkg::cell_flags_t next_flags;

		assign ctrl = '{
			occupied:   (swm_pkg::WIN_W'(g) < fill_q),
			full:       full,
			oldest_age: oldest_age,
			tap:        (swm_pkg::WIN_W'(g) == tap_idx)
		};

		if (g == 0) begin : g_first
			assign prev_entry = '0;
			assign prev_flags = '{ahead: 1'b1, rm: 1'b0};
			assign prev_gone  = 1'b0;
		end else begin : g_lower
			assign prev_entry = entry_arr[g-1];
			assign prev_flags = flag_arr[g-1];
			assign prev_gone  = gone_vec[g-1];
		end

		if (g == WMAX - 1) begin : g_last
			assign next_entry = '0;
			assign next_flags = '0;
		end else begin : g_upper
			assign next_entry = entry_arr[g+1];
			assign next_flags = flag_arr[g+1];
		end

		assign rm_vec[g]   = flag_arr[g].rm;
		assign gone_vec[g] = |(rm_vec << (WMAX - 1 - g));

		swm_cell u_cell (
			.clk        (clk),
			.shift_en   (in_fire),
			.new_key    (new_key),
			.ctrl       (ctrl),
			.prev_entry (prev_entry),
			.prev_flags (prev_flags),
			.prev_gone  (prev_gone),
			.next_entry (next_entry),
			.next_flags (next_flags),
			.gone       (gone_vec[g]),
			.entry      (entry_arr[g]),
			.flags      (flag_arr[g]),
			.tap_key    (tap_arr[g])
		);
	end

	always_comb begin
		tap_or = '0;
		for (int i = 0; i < WMAX; i++) begin
			tap_or = tap_or | tap_arr[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= swm_pkg::WS_RESET;
			fill_q      <= '0;
			emit_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				ws_q   <= ws_new;
				fill_q <= '0;
			end else if (in_fire) begin
				fill_q <= fill_next;
			end
			if (in_fire) begin
				emit_s1 <= emit_next;
			end else if (out_load) begin
				emit_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (median_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_q <= swm_pkg::from_key(tap_or);
		end
	end

	assign median_value = median_q;
	assign median_valid = out_valid_q;

	`SWM_CHECK(a_fill_bound, clk, arst_n, 1'b1, fill_q <= ws_q, "fill count above window size")
	`SWM_CHECK(a_ws_range, clk, arst_n, 1'b1, (ws_q != '0) && (int'(ws_q) <= WMAX), "window size out of range")
	`SWM_CHECK(a_one_oldest, clk, arst_n, full, $onehot(rm_vec), "full window without a single oldest cell")
	`SWM_CHECK(a_no_drop_fill, clk, arst_n, !full, rm_vec == '0, "removal while window filling")
	`SWM_CHECK_NEXT(a_emit_stage, clk, arst_n, in_fire && emit_next, emit_s1, "result word not staged")

endmodule

`default_nettype wire
